[rtl/b64d_pkg.sv]
// Shared types, character codes and the sextet lookup for the Base64 text decoder.
`default_nettype none
package b64d_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [5:0] SX_PLUS  = 6'h3E;
  localparam logic [5:0] SX_SLASH = 6'h3F;
  localparam logic [7:0] OFS_LOWER = 8'd26;
  localparam logic [7:0] OFS_DIGIT = 8'd52;

  localparam logic [1:0] NB_NONE = 2'd0;
  localparam logic [1:0] NB_ONE  = 2'd1;
  localparam logic [1:0] NB_TWO  = 2'd2;
  localparam logic [1:0] NB_FOUR_SLOT = 2'd3;

  // One request from front to back: up to three bytes, byte 0 in the low bits.
  typedef struct packed {
    logic        err;
    logic        done;
    logic [1:0]  nb;
    logic [23:0] bytes;
  } b64d_job_t;

  // Returns {ok, sextet}.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA;
      r = {1'b1, t[5:0]};
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + OFS_LOWER;
      r = {1'b1, t[5:0]};
    end else if (c >= CH_D0 && c <= CH_D9) begin
      t = c - CH_D0 + OFS_DIGIT;
      r = {1'b1, t[5:0]};
    end else if (c == CH_PLUS) begin
      r = {1'b1, SX_PLUS};
    end else if (c == CH_SLASH) begin
      r = {1'b1, SX_SLASH};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/b64d_front.sv]
// Front end: takes characters, keeps the decode state and issues byte requests.
`default_nettype none
module b64d_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [7:0]          char_code,
  input  wire logic                first_of_text,
  input  wire logic                last_of_text,
  input  wire logic                q_full,
  output logic                     in_ready,
  output logic                     push,
  output b64d_pkg::b64d_job_t      job
);

  logic [23:0] acc, acc_next;
  logic [1:0]  slot, slot_next;
  logic        ended, ended_next;
  logic        err, err_next;

  logic [23:0] acc_c, acc_sh;
  logic [1:0]  slot_c, slot_inc;
  logic        ended_c, done;
  logic [6:0]  sx;
  logic [1:0]  nb;
  logic [23:0] bytes;

  assign in_ready = !q_full;

  always_comb begin
    acc_c    = first_of_text ? 24'd0 : acc;
    slot_c   = first_of_text ? 2'd0 : slot;
    ended_c  = first_of_text ? 1'b0 : ended;
    err_next = first_of_text ? 1'b0 : err;
    sx       = b64d_pkg::sextet_of(char_code);
    acc_sh   = {acc_c[17:0], sx[5:0]};
    slot_inc = slot_c + 2'd1;
    acc_next = acc_c;
    slot_next = slot_c;
    ended_next = ended_c;
    done  = 1'b0;
    nb    = b64d_pkg::NB_NONE;
    bytes = 24'd0;
    if (!ended_c) begin
      if (char_code == b64d_pkg::CH_SPACE || char_code == b64d_pkg::CH_NL) begin
        acc_next = acc_c;
      end else if (char_code == b64d_pkg::CH_PAD && slot_c == b64d_pkg::NB_FOUR_SLOT) begin
        bytes = {8'd0, acc_c[9:2], acc_c[17:10]};
        nb    = b64d_pkg::NB_TWO;
        done  = 1'b1;
      end else if (char_code == b64d_pkg::CH_PAD && slot_c == b64d_pkg::NB_TWO) begin
        bytes = {16'd0, acc_c[11:4]};
        nb    = b64d_pkg::NB_ONE;
        done  = 1'b1;
      end else begin
        if (!sx[6]) begin
          err_next = 1'b1;
        end
        acc_next  = acc_sh;
        slot_next = slot_inc;
        if (slot_inc == 2'd0) begin
          bytes    = {acc_sh[7:0], acc_sh[15:8], acc_sh[23:16]};
          nb       = b64d_pkg::NB_FOUR_SLOT;
          acc_next = 24'd0;
        end
      end
      if (!done && last_of_text) begin
        if (slot_next != 2'd0) begin
          err_next = 1'b1;
        end
        done = 1'b1;
      end
      if (done) begin
        ended_next = 1'b1;
        acc_next   = 24'd0;
        slot_next  = 2'd0;
      end
    end
  end

  assign push       = in_valid && in_ready && !ended_c && (nb != b64d_pkg::NB_NONE || done);
  assign job.err    = err_next;
  assign job.done   = done;
  assign job.nb     = nb;
  assign job.bytes  = bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 24'd0;
      slot  <= 2'd0;
      ended <= 1'b0;
      err   <= 1'b0;
    end else if (in_valid && in_ready) begin
      acc   <= acc_next;
      slot  <= slot_next;
      ended <= ended_next;
      err   <= err_next;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_fifo.sv]
// Short request queue between the front and back ends.
`default_nettype none
module b64d_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b64d_pkg::b64d_job_t push_job,
  input  wire logic                pop,
  output logic                     full,
  output logic                     empty,
  output b64d_pkg::b64d_job_t      head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_pkg::b64d_job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_back.sv]
// Back end: splits each request into result items behind an output register.
`default_nettype none
module b64d_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire b64d_pkg::b64d_job_t head,
  output logic                     pop,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [7:0]               byte_value,
  output logic                     byte_valid,
  output logic                     run_last,
  output logic                     text_done,
  output logic                     error_seen
);

  logic [1:0] k;
  logic [1:0] last_k;
  logic       load, is_last;
  logic [7:0] sel_byte;

  always_comb begin
    last_k   = (head.nb == b64d_pkg::NB_NONE) ? 2'd0 : head.nb - 2'd1;
    is_last  = (k == last_k);
    case (k)
      2'd0:    sel_byte = head.bytes[7:0];
      2'd1:    sel_byte = head.bytes[15:8];
      2'd2:    sel_byte = head.bytes[23:16];
      default: sel_byte = 8'd0;
    endcase
  end

  assign load = !q_empty && (!out_valid || out_ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        k         <= is_last ? 2'd0 : k + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_valid <= (head.nb != b64d_pkg::NB_NONE);
      byte_value <= (head.nb == b64d_pkg::NB_NONE) ? 8'd0 : sel_byte;
      run_last   <= is_last;
      text_done  <= head.done;
      error_seen <= head.err;
    end
  end

endmodule
`default_nettype wire

[rtl/base64_text_decoder.sv]
// Top level of the streaming Base64 text decoder.
//
//  channel  | dir | tdata            | tuser                                   | tlast
//  s_axis   | in  | [7:0] char_code  | [0] first_of_text                       | last_of_text
//  m_axis   | out | [7:0] byte_value | [0] byte_valid [1] text_done [2] error  | run_last
//
// One character is taken per cycle while the request queue has room.
// Each character gives zero to three results, sent from the output register one per
// cycle while m_axis_tready is high, after passing through the request queue.
// Reset clears the decode state, the queue and the output register.
// A stalled output fills the queue, then s_axis_tready drops.
`default_nettype none
module base64_text_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire logic       s_axis_tuser,   // [0] first_of_text
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] byte_value
  output logic [2:0]      m_axis_tuser,   // [0] byte_valid, [1] text_done, [2] error_seen
  output logic            m_axis_tlast
);

  b64d_pkg::b64d_job_t job, head;
  logic push, pop, q_full, q_empty;

  b64d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .char_code     (s_axis_tdata),
    .first_of_text (s_axis_tuser),
    .last_of_text  (s_axis_tlast),
    .q_full        (q_full),
    .in_ready      (s_axis_tready),
    .push          (push),
    .job           (job)
  );

  b64d_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .byte_value (m_axis_tdata),
    .byte_valid (m_axis_tuser[0]),
    .run_last   (m_axis_tlast),
    .text_done  (m_axis_tuser[1]),
    .error_seen (m_axis_tuser[2])
  );

endmodule
`default_nettype wire

[rtl/b64d_checker.sv]
// Port checker for the Base64 text decoder and its bind.
`default_nettype none
module b64d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && m_axis_tlast
      && m_axis_tuser[1])
    else $error("malformed status-only result");

  a_reason: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tuser[1])
    else $error("result with neither byte nor end");

endmodule

bind base64_text_decoder b64d_checker u_b64d_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
